/* rtl/core/cts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_pkg - shared types and constants for the trend-smoothing bass boost
// word formats, coefficient constants, control groups and saturation helpers
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int STATE_BITS  = 32;
  localparam int COEF_BITS   = 18;
  localparam int GAIN_BITS   = 17;
  localparam int CFG_IDX_BITS = 2;

  // 0.999 in Q0.18
  localparam logic signed [COEF_BITS:0] COEF_ONE_K = 19'sd261882;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_ALPHA = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BETA  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN  = 2'd2;

  localparam logic [COEF_BITS-1:0] ALPHA_RESET = 18'd345;
  localparam logic [COEF_BITS-1:0] BETA_RESET  = 18'd0;
  localparam logic [GAIN_BITS-1:0] GAIN_RESET  = 17'd0;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [STATE_BITS-1:0]  state_word_t;

  typedef struct packed {
    sample_t left_sample;
    sample_t right_sample;
  } in_word_t;

  typedef struct packed {
    sample_t left_result;
    sample_t right_result;
  } out_word_t;

  // per-lane sequencing strobes
  typedef struct packed {
    logic load;
    logic mul_en;
    logic upd_en;
  } lane_ctrl_t;

  // merge stage strobes
  typedef struct packed {
    logic gain_en;
    logic out_en;
  } merge_ctrl_t;

  // clamp a 36-bit value to the signed state range
  function automatic state_word_t sat_state(input logic signed [35:0] v);
    logic signed [35:0] hi;
    logic signed [35:0] lo;
    hi = 36'sd2147483647;
    lo = -36'sd2147483648;
    if (v > hi) begin
      sat_state = state_word_t'(hi[STATE_BITS-1:0]);
    end else if (v < lo) begin
      sat_state = state_word_t'(lo[STATE_BITS-1:0]);
    end else begin
      sat_state = state_word_t'(v[STATE_BITS-1:0]);
    end
  endfunction

  // clamp a 36-bit value to the signed sample range
  function automatic sample_t sat_sample(input logic signed [35:0] v);
    logic signed [35:0] hi;
    logic signed [35:0] lo;
    hi = 36'sd8388607;
    lo = -36'sd8388608;
    if (v > hi) begin
      sat_sample = sample_t'(hi[SAMPLE_BITS-1:0]);
    end else if (v < lo) begin
      sat_sample = sample_t'(lo[SAMPLE_BITS-1:0]);
    end else begin
      sat_sample = sample_t'(v[SAMPLE_BITS-1:0]);
    end
  endfunction

endpackage

/* rtl/core/cascaded_trend_smoothing_bass_boost_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_trend_smoothing_bass_boost_core - stereo Holt cascade bass boost
// two channel lanes run the smoothing cascade, a merge stage mixes wet/dry
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall / in_data carries one stereo word
//   (left and right sample, signed Q1.23); a word is taken when in_valid is
//   high and in_stall is low
//   result channel: out_valid / out_stall / out_data carries the saturated
//   dry plus boost word; out_data holds while out_stall is high
//   configuration: cfg_we / cfg_idx / cfg_wdata write alpha, beta and wet
//   gain; write only while the block is idle
// timing
//   both lanes step through the cascade one stage at a time (multiply,
//   then round and store); after the last stage come the gain step and the
//   done step, and the result is registered from the done step; a new word
//   is taken only once the last one has left the done step
//   in_stall is high while a word is being worked on
// reset
//   rst_n low clears all stage level and slope state, the sequencer and
//   out_valid, and loads the register defaults
//   a stalled receiver holds the finished word in the output register; the
//   next word is still taken and finishes, then waits for that register
// ----------------------------------------------------------------------------
module cascaded_trend_smoothing_bass_boost_core #(
  parameter int STAGE_COUNT = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  cts_pkg::in_word_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output cts_pkg::out_word_t               out_data,
  input  logic                             cfg_we,
  input  logic [cts_pkg::CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [cts_pkg::COEF_BITS-1:0]    cfg_wdata
);
  import cts_pkg::*;

  localparam int IDX_W = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_STAGE = IDX_W'(STAGE_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_UPD,
    S_GAIN,
    S_DONE
  } seq_state_t;

  seq_state_t state_r;
  logic [IDX_W-1:0] stage_r;
  logic out_valid_r;
  in_word_t dry_r;

  logic [COEF_BITS-1:0] alpha_r, beta_r;
  logic [GAIN_BITS-1:0] gain_r;

  logic in_acc, out_free;
  lane_ctrl_t lane_ctrl;
  merge_ctrl_t merge_ctrl;
  state_word_t boost_l, boost_r;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  // output register can take a new word when empty or being drained
  assign out_free = !out_valid_r || !out_stall;

  assign lane_ctrl.load    = in_acc;
  assign lane_ctrl.mul_en  = (state_r == S_MUL);
  assign lane_ctrl.upd_en  = (state_r == S_UPD);
  assign merge_ctrl.gain_en = (state_r == S_GAIN);
  assign merge_ctrl.out_en  = (state_r == S_DONE) && out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RESET;
      beta_r  <= BETA_RESET;
      gain_r  <= GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ALPHA: alpha_r <= cfg_wdata;
        REG_BETA:  beta_r  <= cfg_wdata;
        REG_GAIN:  gain_r  <= cfg_wdata[GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // stage sequencer and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stage_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a finished word refills the output register as the old one leaves
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            stage_r <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: state_r <= S_UPD;
        S_UPD: begin
          if (stage_r == LAST_STAGE) begin
            state_r <= S_GAIN;
          end else begin
            stage_r <= stage_r + 1'b1;
            state_r <= S_MUL;
          end
        end
        S_GAIN: state_r <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // dry word kept for the final mix
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dry_r <= in_data;
    end
  end

  cts_lane #(
    .STAGE_COUNT(STAGE_COUNT)
  ) u_lane_l (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (lane_ctrl),
    .stage_idx (stage_r),
    .sample_in (in_data.left_sample),
    .alpha     (alpha_r),
    .beta      (beta_r),
    .boost_out (boost_l)
  );

  cts_lane #(
    .STAGE_COUNT(STAGE_COUNT)
  ) u_lane_r (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (lane_ctrl),
    .stage_idx (stage_r),
    .sample_in (in_data.right_sample),
    .alpha     (alpha_r),
    .beta      (beta_r),
    .boost_out (boost_r)
  );

  cts_merge u_merge (
    .clk      (clk),
    .ctrl     (merge_ctrl),
    .boost_l  (boost_l),
    .boost_r  (boost_r),
    .dry      (dry_r),
    .gain     (gain_r),
    .out_word (out_data)
  );

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  // a taken word blocks the input on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input not stalled after a word was taken");

  // stage counter stays inside the cascade
  a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
    stage_r <= LAST_STAGE)
    else $error("stage index beyond last stage");

  // last stage update hands over to the merge stage
  a_last_to_gain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && stage_r == LAST_STAGE) |=> (state_r == S_GAIN))
    else $error("cascade end did not move to gain step");

  // a result only appears from the done step
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside done step");
`endif

endmodule

/* rtl/core/cts_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_lane - one channel of the cascaded Holt smoothing filter
// walks the stages one at a time: multiply cycle, then update cycle
// ----------------------------------------------------------------------------
module cts_lane #(
  parameter int STAGE_COUNT = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cts_pkg::lane_ctrl_t               ctrl,
  input  logic [((STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1)-1:0] stage_idx,
  input  cts_pkg::sample_t                  sample_in,
  input  logic [cts_pkg::COEF_BITS-1:0]     alpha,
  input  logic [cts_pkg::COEF_BITS-1:0]     beta,
  output cts_pkg::state_word_t              boost_out
);
  import cts_pkg::*;

  state_word_t level_r [STAGE_COUNT];
  state_word_t slope_r [STAGE_COUNT];
  state_word_t x_r;

  logic signed [51:0] bd_r, kt_r, ax_r, kp_r;
  logic signed [51:0] bd_nxt, kt_nxt, ax_nxt, kp_nxt;

  logic signed [COEF_BITS:0] a_s, b_s, ka_s, kb_s;
  state_word_t p, t;
  logic signed [32:0] diff, pt_sum;
  logic signed [53:0] tr_sum, nx_sum;
  state_word_t tr_sat, nx_sat;

  assign a_s  = signed'({1'b0, alpha});
  assign b_s  = signed'({1'b0, beta});
  assign ka_s = COEF_ONE_K - a_s;
  assign kb_s = COEF_ONE_K - b_s;

  assign p      = level_r[stage_idx];
  assign t      = slope_r[stage_idx];
  assign diff   = {x_r[31], x_r} - {p[31], p};
  assign pt_sum = {p[31], p} + {t[31], t};

  assign bd_nxt = b_s * diff;
  assign kt_nxt = kb_s * t;
  assign ax_nxt = a_s * x_r;
  assign kp_nxt = ka_s * pt_sum;

  // round half up, then drop 18 fraction bits
  assign tr_sum = {{2{bd_r[51]}}, bd_r} + {{2{kt_r[51]}}, kt_r} + 54'sd131072;
  assign nx_sum = {{2{ax_r[51]}}, ax_r} + {{2{kp_r[51]}}, kp_r} + 54'sd131072;
  assign tr_sat = sat_state(tr_sum[53:18]);
  assign nx_sat = sat_state(nx_sum[53:18]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STAGE_COUNT; i++) begin
        level_r[i] <= '0;
        slope_r[i] <= '0;
      end
    end else if (ctrl.upd_en) begin
      level_r[stage_idx] <= nx_sat;
      slope_r[stage_idx] <= tr_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x_r <= state_word_t'({{(STATE_BITS-SAMPLE_BITS){sample_in[SAMPLE_BITS-1]}}, sample_in});
    end else if (ctrl.upd_en) begin
      x_r <= nx_sat;
    end
    if (ctrl.mul_en) begin
      bd_r <= bd_nxt;
      kt_r <= kt_nxt;
      ax_r <= ax_nxt;
      kp_r <= kp_nxt;
    end
  end

  assign boost_out = x_r;

endmodule

/* rtl/core/cts_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_merge - combines both lanes with the dry word
// scales each boost by the wet gain, adds the dry sample, saturates
// ----------------------------------------------------------------------------
module cts_merge (
  input  logic                          clk,
  input  cts_pkg::merge_ctrl_t          ctrl,
  input  cts_pkg::state_word_t          boost_l,
  input  cts_pkg::state_word_t          boost_r,
  input  cts_pkg::in_word_t             dry,
  input  logic [cts_pkg::GAIN_BITS-1:0] gain,
  output cts_pkg::out_word_t            out_word
);
  import cts_pkg::*;

  logic signed [GAIN_BITS:0] g_s;
  logic signed [49:0] prod_l_r, prod_r_r;
  logic signed [49:0] prod_l_nxt, prod_r_nxt;
  logic signed [50:0] wet_l_sum, wet_r_sum;
  logic signed [35:0] tot_l, tot_r;
  out_word_t out_r;

  assign g_s        = signed'({1'b0, gain});
  assign prod_l_nxt = boost_l * g_s;
  assign prod_r_nxt = boost_r * g_s;

  // round half up by 2^15, shift by 16
  assign wet_l_sum = {prod_l_r[49], prod_l_r} + 51'sd32768;
  assign wet_r_sum = {prod_r_r[49], prod_r_r} + 51'sd32768;
  assign tot_l = {{12{dry.left_sample[SAMPLE_BITS-1]}}, dry.left_sample}
               + {wet_l_sum[50], wet_l_sum[50:16]};
  assign tot_r = {{12{dry.right_sample[SAMPLE_BITS-1]}}, dry.right_sample}
               + {wet_r_sum[50], wet_r_sum[50:16]};

  always_ff @(posedge clk) begin
    if (ctrl.gain_en) begin
      prod_l_r <= prod_l_nxt;
      prod_r_r <= prod_r_nxt;
    end
    if (ctrl.out_en) begin
      out_r.left_result  <= sat_sample(tot_l);
      out_r.right_result <= sat_sample(tot_r);
    end
  end

  assign out_word = out_r;

endmodule
